[sv/stb_pkg.sv]
// Shared types, op and status codes, and sizing constants for the soft timer bank.
package stb_pkg;

   localparam int TIMER_COUNT = 8;
   localparam int IDX_W       = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
   localparam int MASK_W      = 8;
   localparam int RUN_W       = 31;

   typedef enum logic [2:0] {
      OP_TICK   = 3'd0,
      OP_CREATE = 3'd1,
      OP_DELETE = 3'd2,
      OP_CHECK  = 3'd3,
      OP_ELAPSE = 3'd4,
      OP_DELAY  = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_CONFLICT = 2'd1,
      ST_RANGE    = 2'd2
   } status_type;

   // controller -> datapath
   typedef struct packed {
      logic exec;      // input beat accepted this cycle
      logic walk;      // process one timer of the tick walk
      logic rsp_load;  // capture the result register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic walk_last; // walk index sits on the last timer
   } sts_type;

endpackage

[sv/stb_ctrl.sv]
// Controller state machine: input/result handshakes and tick-walk sequencing.
module stb_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_op,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output stb_pkg::cmd_type   cmd,
   input  stb_pkg::sts_type   sts
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_WALK = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      is_tick;

   assign is_tick   = (req_op == stb_pkg::OP_TICK);
   assign req_stall = !((state_ff == S_IDLE) && (!rsp_valid_ff || !rsp_stall));
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.exec     = accept;
      cmd.walk     = (state_ff == S_WALK);
      cmd.rsp_load = (accept && !is_tick) || ((state_ff == S_WALK) && sts.walk_last);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && is_tick) begin
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            if (sts.walk_last) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_walk_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> req_stall)
      else $error("input accepted during tick walk");

   a_walk_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> !rsp_valid_ff)
      else $error("result pending during tick walk");

   a_tick_starts_walk: assert property (@(posedge clock) disable iff (reset)
      (accept && is_tick) |=> (state_ff == S_WALK))
      else $error("tick beat did not start walk");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("result register overwritten while stalled");

endmodule

[sv/stb_dp.sv]
// Datapath: timer bank state, run-time and delay counters, result register.
module stb_dp (
   input  logic              clock,
   input  logic              reset,
   input  stb_pkg::cmd_type  cmd,
   output stb_pkg::sts_type  sts,
   input  logic [2:0]        req_op,
   input  logic [7:0]        req_timer_id,
   input  logic [31:0]       req_period,
   input  logic              req_auto_reload,
   input  logic [30:0]       req_last_time,
   input  logic [31:0]       req_delay_length,
   output logic [1:0]        rsp_status,
   output logic              rsp_expired,
   output logic [7:0]        rsp_expire_mask,
   output logic [30:0]       rsp_run_time,
   output logic [30:0]       rsp_elapsed,
   output logic              rsp_delay_done
);

   localparam int N = stb_pkg::TIMER_COUNT;
   localparam int W = stb_pkg::IDX_W;

   logic [31:0] count_ff  [N];
   logic [31:0] count_in  [N];
   logic [31:0] reload_ff [N];
   logic [31:0] reload_in [N];
   logic [N-1:0] flag_ff, flag_in;
   logic [N-1:0] auto_ff, auto_in;
   logic [N-1:0] used_ff, used_in;

   logic [30:0] run_ff, run_in, run_inc;
   logic [31:0] dcnt_ff, dcnt_in, dcnt_dec;
   logic        dflag_ff, dflag_in;

   logic [W-1:0] idx_ff, idx_in;
   logic [7:0]   mask_ff, mask_in, idx8;

   logic [1:0]  st_ff;
   logic        exp_ff;
   logic [7:0]  msk_ff;
   logic [30:0] rt_ff, el_ff;
   logic        dd_ff;

   stb_pkg::status_type status_c;
   logic        expired_c;
   logic [30:0] elapsed_c;

   logic [W-1:0] id_sel;
   logic         in_range;
   logic [31:0]  walk_cnt, walk_dec;

   assign id_sel   = req_timer_id[W-1:0];
   assign in_range = (req_timer_id < 8'(N));
   assign walk_cnt = count_ff[idx_ff];
   assign walk_dec = walk_cnt - 32'd1;
   assign idx8     = 8'(idx_ff);
   assign run_inc  = run_ff + 31'd1;
   assign dcnt_dec = dcnt_ff - 32'd1;

   assign sts.walk_last = (idx_ff == W'(N - 1));

   always_comb begin
      count_in  = count_ff;
      reload_in = reload_ff;
      flag_in   = flag_ff;
      auto_in   = auto_ff;
      used_in   = used_ff;
      run_in    = run_ff;
      dcnt_in   = dcnt_ff;
      dflag_in  = dflag_ff;
      idx_in    = idx_ff;
      mask_in   = mask_ff;
      status_c  = stb_pkg::ST_OK;
      expired_c = 1'b0;
      elapsed_c = 31'd0;

      if (cmd.exec) begin
         case (req_op)
            stb_pkg::OP_TICK: begin
               if (dcnt_ff != 32'd0) begin
                  dcnt_in = dcnt_dec;
                  if (dcnt_dec == 32'd0) begin
                     dflag_in = 1'b1;
                  end
               end
               // run time wraps to zero at all ones
               run_in  = (run_inc == 31'h7FFF_FFFF) ? 31'd0 : run_inc;
               idx_in  = '0;
               mask_in = 8'd0;
            end
            stb_pkg::OP_CREATE: begin
               if (!in_range) begin
                  status_c = stb_pkg::ST_RANGE;
               end else if (used_ff[id_sel]) begin
                  status_c = stb_pkg::ST_CONFLICT;
               end else begin
                  count_in[id_sel]  = req_period;
                  reload_in[id_sel] = req_period;
                  flag_in[id_sel]   = 1'b0;
                  auto_in[id_sel]   = req_auto_reload;
                  used_in[id_sel]   = 1'b1;
               end
            end
            stb_pkg::OP_DELETE: begin
               if (!in_range) begin
                  status_c = stb_pkg::ST_RANGE;
               end else if (!used_ff[id_sel]) begin
                  status_c = stb_pkg::ST_CONFLICT;
               end else begin
                  count_in[id_sel]  = 32'd0;
                  reload_in[id_sel] = 32'd0;
                  auto_in[id_sel]   = 1'b0;
                  used_in[id_sel]   = 1'b0;
               end
            end
            stb_pkg::OP_CHECK: begin
               if (!in_range) begin
                  status_c = stb_pkg::ST_RANGE;
               end else if (!used_ff[id_sel]) begin
                  status_c = stb_pkg::ST_CONFLICT;
               end else begin
                  expired_c = flag_ff[id_sel];
               end
            end
            stb_pkg::OP_ELAPSE: begin
               // wrapped case is one short of the plain modular difference
               elapsed_c = run_ff - req_last_time
                         - ((run_ff < req_last_time) ? 31'd1 : 31'd0);
            end
            stb_pkg::OP_DELAY: begin
               if (req_delay_length != 32'd0) begin
                  dcnt_in  = (req_delay_length == 32'd1) ? 32'd2 : req_delay_length;
                  dflag_in = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end

      if (cmd.walk) begin
         if (walk_cnt != 32'd0) begin
            count_in[idx_ff] = walk_dec;
            if (walk_dec == 32'd0) begin
               flag_in[idx_ff] = 1'b1;
               if (auto_ff[idx_ff]) begin
                  count_in[idx_ff] = reload_ff[idx_ff];
               end
               if (idx8 < 8'd8) begin
                  mask_in = mask_ff | (8'd1 << idx8[2:0]);
               end
            end
         end
         idx_in = idx_ff + W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < N; k++) begin
            count_ff[k]  <= 32'd0;
            reload_ff[k] <= 32'd0;
         end
         flag_ff  <= '0;
         auto_ff  <= '0;
         used_ff  <= '0;
         run_ff   <= 31'd0;
         dcnt_ff  <= 32'd0;
         dflag_ff <= 1'b0;
         idx_ff   <= '0;
         mask_ff  <= 8'd0;
      end else begin
         count_ff  <= count_in;
         reload_ff <= reload_in;
         flag_ff   <= flag_in;
         auto_ff   <= auto_in;
         used_ff   <= used_in;
         run_ff    <= run_in;
         dcnt_ff   <= dcnt_in;
         dflag_ff  <= dflag_in;
         idx_ff    <= idx_in;
         mask_ff   <= mask_in;
      end
   end

   // result register, payload only
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         st_ff  <= status_c;
         exp_ff <= expired_c;
         msk_ff <= cmd.walk ? mask_in : 8'd0;
         rt_ff  <= run_in;
         el_ff  <= elapsed_c;
         dd_ff  <= dflag_in;
      end
   end

   assign rsp_status      = st_ff;
   assign rsp_expired     = exp_ff;
   assign rsp_expire_mask = msk_ff;
   assign rsp_run_time    = rt_ff;
   assign rsp_elapsed     = el_ff;
   assign rsp_delay_done  = dd_ff;

endmodule

[sv/soft_timer_bank_core.sv]
// Top level of the soft timer bank: controller plus datapath.
//
//   channel   direction   handshake            payload
//   req       in          req_valid/req_stall  op, timer_id, period, auto_reload,
//                                              last_time, delay_length
//   rsp       out         rsp_valid/rsp_stall  status, expired, expire_mask,
//                                              run_time, elapsed, delay_done
//
// Non-tick beats: result registered at the accept edge, one beat per cycle while rsp is not stalled.
// Tick beats: the walk updates one timer per cycle.
// Input is stalled during the walk and while a finished result is stalled.
// Synchronous reset clears all timers, counters and the handshake state.
module soft_timer_bank_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_op,
   input  logic [7:0]  req_timer_id,
   input  logic [31:0] req_period,
   input  logic        req_auto_reload,
   input  logic [30:0] req_last_time,
   input  logic [31:0] req_delay_length,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic        rsp_expired,
   output logic [7:0]  rsp_expire_mask,
   output logic [30:0] rsp_run_time,
   output logic [30:0] rsp_elapsed,
   output logic        rsp_delay_done
);

   stb_pkg::cmd_type cmd;
   stb_pkg::sts_type sts;

   stb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_op    (req_op),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   stb_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_op           (req_op),
      .req_timer_id     (req_timer_id),
      .req_period       (req_period),
      .req_auto_reload  (req_auto_reload),
      .req_last_time    (req_last_time),
      .req_delay_length (req_delay_length),
      .rsp_status       (rsp_status),
      .rsp_expired      (rsp_expired),
      .rsp_expire_mask  (rsp_expire_mask),
      .rsp_run_time     (rsp_run_time),
      .rsp_elapsed      (rsp_elapsed),
      .rsp_delay_done   (rsp_delay_done)
   );

endmodule

[verif/soft_timer_bank_core_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for soft_timer_bank_core: directed and random beats against a shadow.
module soft_timer_bank_core_test;

   localparam logic [2:0]  OP_SPARE6  = 3'd6;
   localparam logic [2:0]  OP_SPARE7  = 3'd7;
   localparam logic [30:0] RUN_WRAP   = 31'h7FFFFFFF;
   localparam int          HANG_LIMIT = 2000;

   typedef struct packed {
      logic [2:0]  op;
      logic [7:0]  timer_id;
      logic [31:0] period;
      logic        auto_reload;
      logic [30:0] last_time;
      logic [31:0] delay_length;
   } timer_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        expired;
      logic [7:0]  expire_mask;
      logic [30:0] run_time;
      logic [30:0] elapsed;
      logic        delay_done;
   } timer_rsp_type;

   // Shadow copy of the timer bank; predicts one reply per request beat.
   class timer_bank_tracker_type;
      bit [31:0]     count[stb_pkg::TIMER_COUNT];
      bit [31:0]     reload[stb_pkg::TIMER_COUNT];
      bit            flag[stb_pkg::TIMER_COUNT];
      bit            auto_mode[stb_pkg::TIMER_COUNT];
      bit            used[stb_pkg::TIMER_COUNT];
      bit [30:0]     run_count;
      bit [31:0]     delay_left;
      bit            delay_over;
      timer_rsp_type pending_replies[$];
      int            errors;

      function new();
         errors = 0;
      endfunction

      function int pending();
         return pending_replies.size();
      endfunction

      function void note_request(timer_req_type r);
         timer_rsp_type x;
         int            k;
         x = '0;
         case (r.op)
            stb_pkg::OP_TICK: begin
               if (delay_left != 0) begin
                  delay_left--;
                  if (delay_left == 0) delay_over = 1'b1;
               end
               run_count = (run_count + 31'd1 == RUN_WRAP) ? 31'd0 : run_count + 31'd1;
               for (k = 0; k < stb_pkg::TIMER_COUNT; k++) begin
                  if (count[k] != 0) begin
                     count[k]--;
                     if (count[k] == 0) begin
                        flag[k] = 1'b1;
                        if (auto_mode[k]) count[k] = reload[k];
                        if (k < stb_pkg::MASK_W) x.expire_mask[k] = 1'b1;
                     end
                  end
               end
            end
            stb_pkg::OP_CREATE: begin
               if (r.timer_id >= stb_pkg::TIMER_COUNT) x.status = stb_pkg::ST_RANGE;
               else if (used[r.timer_id]) x.status = stb_pkg::ST_CONFLICT;
               else begin
                  count[r.timer_id]     = r.period;
                  reload[r.timer_id]    = r.period;
                  flag[r.timer_id]      = 1'b0;
                  auto_mode[r.timer_id] = r.auto_reload;
                  used[r.timer_id]      = 1'b1;
               end
            end
            stb_pkg::OP_DELETE: begin
               if (r.timer_id >= stb_pkg::TIMER_COUNT) x.status = stb_pkg::ST_RANGE;
               else if (!used[r.timer_id]) x.status = stb_pkg::ST_CONFLICT;
               else begin
                  // expired flag survives a delete
                  count[r.timer_id]     = 0;
                  reload[r.timer_id]    = 0;
                  auto_mode[r.timer_id] = 1'b0;
                  used[r.timer_id]      = 1'b0;
               end
            end
            stb_pkg::OP_CHECK: begin
               if (r.timer_id >= stb_pkg::TIMER_COUNT) x.status = stb_pkg::ST_RANGE;
               else if (!used[r.timer_id]) x.status = stb_pkg::ST_CONFLICT;
               else x.expired = flag[r.timer_id];
            end
            stb_pkg::OP_ELAPSE: begin
               if (run_count >= r.last_time) x.elapsed = run_count - r.last_time;
               else x.elapsed = RUN_WRAP - r.last_time + run_count;
            end
            stb_pkg::OP_DELAY: begin
               if (r.delay_length != 0) begin
                  delay_left = (r.delay_length == 1) ? 32'd2 : r.delay_length;
                  delay_over = 1'b0;
               end
            end
            default: ;
         endcase
         x.run_time   = run_count;
         x.delay_done = delay_over;
         pending_replies.push_back(x);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_reply(timer_rsp_type got);
         timer_rsp_type want;
         if (pending_replies.size() == 0) begin
            $error("reply beat with no request outstanding");
            errors++;
            return;
         end
         want = pending_replies.pop_front();
         compare_field("status", want.status, got.status);
         compare_field("expired", want.expired, got.expired);
         compare_field("expire_mask", want.expire_mask, got.expire_mask);
         compare_field("run_time", want.run_time, got.run_time);
         compare_field("elapsed", want.elapsed, got.elapsed);
         compare_field("delay_done", want.delay_done, got.delay_done);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_op;
   logic [7:0]  req_timer_id;
   logic [31:0] req_period;
   logic        req_auto_reload;
   logic [30:0] req_last_time;
   logic [31:0] req_delay_length;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_status;
   logic        rsp_expired;
   logic [7:0]  rsp_expire_mask;
   logic [30:0] rsp_run_time;
   logic [30:0] rsp_elapsed;
   logic        rsp_delay_done;

   timer_bank_tracker_type book = new();
   int idle_max = 18;
   int quiet_cycles = 0;

   soft_timer_bank_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_timer_id     (req_timer_id),
      .req_period       (req_period),
      .req_auto_reload  (req_auto_reload),
      .req_last_time    (req_last_time),
      .req_delay_length (req_delay_length),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_expired      (rsp_expired),
      .rsp_expire_mask  (rsp_expire_mask),
      .rsp_run_time     (rsp_run_time),
      .rsp_elapsed      (rsp_elapsed),
      .rsp_delay_done   (rsp_delay_done)
   );

   always #2 clock = ~clock;

   function automatic timer_req_type compose(logic [2:0] op, logic [7:0] id,
                                             logic [31:0] period, logic auto_rl,
                                             logic [30:0] last, logic [31:0] dlen);
      timer_req_type r;
      r.op           = op;
      r.timer_id     = id;
      r.period       = period;
      r.auto_reload  = auto_rl;
      r.last_time    = last;
      r.delay_length = dlen;
      return r;
   endfunction

   function automatic timer_req_type random_request();
      timer_req_type r;
      int            pick;
      pick = $urandom_range(0, 99);
      if (pick < 38) r.op = stb_pkg::OP_TICK;
      else if (pick < 54) r.op = stb_pkg::OP_CREATE;
      else if (pick < 64) r.op = stb_pkg::OP_DELETE;
      else if (pick < 76) r.op = stb_pkg::OP_CHECK;
      else if (pick < 86) r.op = stb_pkg::OP_ELAPSE;
      else if (pick < 95) r.op = stb_pkg::OP_DELAY;
      else r.op = pick[0] ? OP_SPARE7 : OP_SPARE6;
      r.timer_id = ($urandom_range(0, 9) != 0)
                 ? 8'($urandom_range(0, stb_pkg::TIMER_COUNT - 1))
                 : 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 9);
      if (pick == 0) r.period = $urandom;
      else if (pick < 3) r.period = $urandom_range(0, 2);
      else r.period = $urandom_range(3, 30);
      r.auto_reload  = 1'($urandom_range(0, 1));
      r.last_time    = ($urandom_range(0, 1) != 0) ? 31'($urandom_range(0, 400)) : 31'($urandom);
      r.delay_length = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 25) : $urandom;
      return r;
   endfunction

   // called at a rising edge; returns at the edge that takes the beat
   task automatic drive_request(timer_req_type r);
      int gap;
      bit fire;
      gap = $urandom_range(0, idle_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_op           <= r.op;
      req_timer_id     <= r.timer_id;
      req_period       <= r.period;
      req_auto_reload  <= r.auto_reload;
      req_last_time    <= r.last_time;
      req_delay_length <= r.delay_length;
      do begin
         @(negedge clock);
         fire = req_valid && !req_stall;
         @(posedge clock);
      end while (!fire);
   endtask

   task automatic drain_replies();
      req_valid <= 1'b0;
      do @(posedge clock); while (book.pending() != 0);
   endtask

   // reply side: random stall per beat
   initial begin
      int  n;
      bit  fire;
      rsp_stall = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         n = $urandom_range(0, idle_max);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do begin
            @(negedge clock);
            fire = rsp_valid && !rsp_stall;
            if (!fire) @(posedge clock);
         end while (!fire);
      end
   end

   // everything is settled mid-cycle, so a beat seen here is taken at the next edge
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            book.note_request(compose(req_op, req_timer_id, req_period, req_auto_reload,
                                      req_last_time, req_delay_length));
         if (rsp_valid && !rsp_stall)
            book.check_reply({rsp_status, rsp_expired, rsp_expire_mask, rsp_run_time,
                              rsp_elapsed, rsp_delay_done});
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= HANG_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin
      int n;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_op           = stb_pkg::OP_TICK;
      req_timer_id     = '0;
      req_period       = '0;
      req_auto_reload  = 1'b0;
      req_last_time    = '0;
      req_delay_length = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      drive_request(compose(stb_pkg::OP_TICK,   8'd0,   32'd0,        1'b0, 31'd0, 32'd0));
      drive_request(compose(stb_pkg::OP_CREATE, 8'd0,   32'd3,        1'b1, 31'd0, 32'd0));
      drive_request(compose(stb_pkg::OP_CREATE, 8'd0,   32'd5,        1'b0, 31'd0, 32'd0));
      drive_request(compose(stb_pkg::OP_CREATE, 8'd255, 32'hFFFFFFFF, 1'b1, 31'd0, 32'd0));
      drive_request(compose(stb_pkg::OP_CREATE, 8'd8,   32'd4,        1'b0, 31'd0, 32'd0));
      drive_request(compose(stb_pkg::OP_CREATE, 8'd7,   32'hFFFFFFFF, 1'b0, 31'd0, 32'd0));
      drive_request(compose(stb_pkg::OP_CREATE, 8'd1,   32'd0,        1'b0, 31'd0, 32'd0));
      drive_request(compose(stb_pkg::OP_CREATE, 8'd2,   32'd1,        1'b0, 31'd0, 32'd0));
      drive_request(compose(stb_pkg::OP_DELAY,  8'd0,   32'd0,        1'b0, 31'd0, 32'd1));
      drive_request(compose(stb_pkg::OP_TICK,   8'd0,   32'd0,        1'b0, 31'd0, 32'd0));
      drive_request(compose(stb_pkg::OP_TICK,   8'd0,   32'd0,        1'b0, 31'd0, 32'd0));
      drive_request(compose(stb_pkg::OP_DELAY,  8'd0,   32'd0,        1'b0, 31'd0, 32'd0));
      drive_request(compose(stb_pkg::OP_TICK,   8'd0,   32'd0,        1'b0, 31'd0, 32'd0));
      drive_request(compose(stb_pkg::OP_TICK,   8'd0,   32'd0,        1'b0, 31'd0, 32'd0));
      drive_request(compose(stb_pkg::OP_CHECK,  8'd2,   32'd0,        1'b0, 31'd0, 32'd0));
      drive_request(compose(stb_pkg::OP_CHECK,  8'd3,   32'd0,        1'b0, 31'd0, 32'd0));
      drive_request(compose(stb_pkg::OP_CHECK,  8'd200, 32'd0,        1'b0, 31'd0, 32'd0));
      drive_request(compose(stb_pkg::OP_DELETE, 8'd2,   32'd0,        1'b0, 31'd0, 32'd0));
      drive_request(compose(stb_pkg::OP_CHECK,  8'd2,   32'd0,        1'b0, 31'd0, 32'd0));
      drive_request(compose(stb_pkg::OP_DELETE, 8'd2,   32'd0,        1'b0, 31'd0, 32'd0));
      drive_request(compose(stb_pkg::OP_ELAPSE, 8'd0,   32'd0,        1'b0, 31'd0, 32'd0));
      drive_request(compose(stb_pkg::OP_ELAPSE, 8'd0,   32'd0,        1'b0, RUN_WRAP, 32'd0));
      drive_request(compose(stb_pkg::OP_ELAPSE, 8'd0,   32'd0,        1'b0, 31'h7FFFFFFE,
                            32'd0));
      drive_request(compose(OP_SPARE6, 8'd0,   32'd0,          1'b0, 31'd0, 32'd0));
      drive_request(compose(OP_SPARE7, 8'hFF,  32'hFFFFFFFF,   1'b1, RUN_WRAP, 32'hFFFFFFFF));

      for (n = 0; n < 575; n++) begin
         // some stretches run with no idling on either side
         if (n % 50 == 0) idle_max = ($urandom_range(0, 3) == 0) ? 0 : 18;
         if (n == 300) drain_replies();
         drive_request(random_request());
      end

      drain_replies();
      repeat (3 * (stb_pkg::TIMER_COUNT + 1)) @(posedge clock);
      if (book.errors == 0 && book.pending() == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule
